@@ hw/rtl/bad_pkg.sv @@
// Shared types and constants for the box-average downsampler.
// Used by bad_controller, bad_datapath and box_average_downsampler.
`default_nettype none

package bad_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_FACTOR  = 16;

   localparam int PIX_W       = 8;
   localparam int SUM_W       = 16;
   localparam int DIVIDEND_W  = SUM_W + 1;
   localparam int COL_W       = 12;
   localparam int ROW_W       = 16;
   localparam int FAC_W       = 5;
   localparam int IMG_W_W     = 13;
   localparam int SUB_W       = 4;
   localparam int AREA_W      = 9;
   localparam int DIV_STEPS   = 8;
   localparam int STEP_W      = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACTOR = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              accept;
      logic              accumulate;
      logic              div_step;
      logic [STEP_W-1:0] div_shift;
      logic              out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic completes;
      logic out_busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/bad_controller.sv @@
// Sequencer for the box-average downsampler: item acceptance, accumulate,
// eight-step division and result hand-off. Depends on bad_pkg.
`default_nettype none

module bad_controller
   import bad_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.accept     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.accumulate = (state_ff == ST_ACC);
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.div_shift  = step_ff;
      cmd.out_load   = (state_ff == ST_OUT) && !status.out_busy;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            // Quotient bits are produced from the top bit down.
            step_in  = STEP_W'(DIV_STEPS - 1);
            state_in = status.completes ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bad_datapath.sv @@
// Datapath of the box-average downsampler: registers, position counters,
// column sum memory, restoring divider and result register. Depends on bad_pkg.
`default_nettype none

module bad_datapath
   import bad_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic [PIX_W-1:0]      pixel_value,
   input  wire ctrl_cmd_type          cmd,
   output ctrl_status_type            status,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [PIX_W-1:0]           average_value,
   output logic                       frame_last
);

   // Configuration registers and their clamped working values.
   logic [FAC_W-1:0]   factor_ff;
   logic [IMG_W_W-1:0] width_ff;
   logic [ROW_W-1:0]   height_ff;
   logic [FAC_W-1:0]   f_eff;
   logic [IMG_W_W-1:0] w_eff;
   logic [ROW_W-1:0]   h_eff;
   logic [FAC_W-1:0]   f_m1;
   logic [AREA_W-1:0]  area_ff;
   logic               restart;

   // Position counters.
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [SUB_W-1:0]   wbc_ff;
   logic [SUB_W-1:0]   wbr_ff;
   logic [COL_W-1:0]   ocol_ff;
   logic [IMG_W_W-1:0] bcs_ff;
   logic [ROW_W-1:0]   brs_ff;

   logic               col_ok, row_ok, col_lastblk, row_lastblk;
   logic               wbc_end, wbr_end, row_end, frame_end;

   // Per-item snapshot.
   logic [PIX_W-1:0]   pix_ff;
   logic [COL_W-1:0]   addr_ff;
   logic               first_ff, inr_ff, comp_ff, last_ff;
   logic [SUM_W-1:0]   rd_ff;
   logic [SUM_W-1:0]   sum_new;

   logic [SUM_W-1:0]   sum_mem [MAX_WIDTH];

   // Divider.
   logic [DIVIDEND_W-1:0] rem_ff;
   logic [PIX_W-1:0]      quo_ff;
   logic [DIVIDEND_W-1:0] div_trial;
   logic                  div_ge;

   logic                  rsp_valid_ff;
   logic [PIX_W-1:0]      rsp_data_ff;
   logic                  rsp_last_ff;

   always_comb begin
      f_eff = factor_ff;
      if (factor_ff == '0) begin
         f_eff = FAC_W'(1);
      end else if (factor_ff > FAC_W'(MAX_FACTOR)) begin
         f_eff = FAC_W'(MAX_FACTOR);
      end
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = IMG_W_W'(1);
      end else if (width_ff > IMG_W_W'(MAX_WIDTH)) begin
         w_eff = IMG_W_W'(MAX_WIDTH);
      end
      h_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;
   end

   assign f_m1 = f_eff - 1'b1;

   // A block column is inside the image when its whole span fits the row;
   // the last block column is the one after which no further block fits.
   assign col_ok      = ({1'b0, bcs_ff} + {{(IMG_W_W - FAC_W + 1){1'b0}}, f_eff})
                        <= {1'b0, w_eff};
   assign col_lastblk = ({1'b0, bcs_ff} + {{(IMG_W_W - FAC_W){1'b0}}, f_eff, 1'b0})
                        > {1'b0, w_eff};
   assign row_ok      = ({1'b0, brs_ff} + {{(ROW_W - FAC_W + 1){1'b0}}, f_eff})
                        <= {1'b0, h_eff};
   assign row_lastblk = ({1'b0, brs_ff} + {{(ROW_W - FAC_W){1'b0}}, f_eff, 1'b0})
                        > {1'b0, h_eff};
   assign wbc_end     = ({1'b0, wbc_ff} == f_m1);
   assign wbr_end     = ({1'b0, wbr_ff} == f_m1);
   assign row_end     = ({1'b0, col_ff} + 1'b1) >= w_eff;
   assign frame_end   = ({1'b0, row_ff} + 1'b1) >= {1'b0, h_eff};

   always_comb begin
      case (csr_index)
         CSR_FACTOR, CSR_WIDTH, CSR_HEIGHT: restart = csr_valid;
         default:                            restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FAC_W'(1);
         width_ff  <= IMG_W_W'(MAX_WIDTH);
         height_ff <= ROW_W'(4096);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FACTOR: factor_ff <= csr_data[FAC_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_data[IMG_W_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(f_eff) * AREA_W'(f_eff);
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         wbc_ff  <= '0;
         wbr_ff  <= '0;
         ocol_ff <= '0;
         bcs_ff  <= '0;
         brs_ff  <= '0;
      end else if (cmd.accept) begin
         if (row_end) begin
            col_ff  <= '0;
            wbc_ff  <= '0;
            ocol_ff <= '0;
            bcs_ff  <= '0;
            if (frame_end) begin
               row_ff <= '0;
               wbr_ff <= '0;
               brs_ff <= '0;
            end else begin
               row_ff <= row_ff + 1'b1;
               if (wbr_end) begin
                  wbr_ff <= '0;
                  brs_ff <= brs_ff + ROW_W'(f_eff);
               end else begin
                  wbr_ff <= wbr_ff + 1'b1;
               end
            end
         end else begin
            col_ff <= col_ff + 1'b1;
            if (wbc_end) begin
               wbc_ff  <= '0;
               ocol_ff <= ocol_ff + 1'b1;
               bcs_ff  <= bcs_ff + IMG_W_W'(f_eff);
            end else begin
               wbc_ff <= wbc_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inr_ff  <= 1'b0;
         comp_ff <= 1'b0;
      end else if (cmd.accept) begin
         inr_ff  <= col_ok && row_ok;
         comp_ff <= col_ok && row_ok && wbc_end && wbr_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff   <= pixel_value;
         addr_ff  <= ocol_ff;
         first_ff <= (wbc_ff == '0) && (wbr_ff == '0);
         last_ff  <= col_lastblk && row_lastblk;
         rd_ff    <= sum_mem[ocol_ff];
      end
   end

   assign sum_new = first_ff ? SUM_W'(pix_ff) : rd_ff + SUM_W'(pix_ff);

   always_ff @(posedge clock) begin
      if (cmd.accumulate && inr_ff) begin
         sum_mem[addr_ff] <= sum_new;
      end
   end

   // Rounded mean: (sum + area/2) / area, one quotient bit per cycle.
   assign div_trial = DIVIDEND_W'(area_ff) << cmd.div_shift;
   assign div_ge    = rem_ff >= div_trial;

   always_ff @(posedge clock) begin
      if (cmd.accumulate) begin
         rem_ff <= DIVIDEND_W'(sum_new) + DIVIDEND_W'(area_ff >> 1);
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= rem_ff - div_trial;
         end
         quo_ff <= {quo_ff[PIX_W-2:0], div_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= quo_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign status.completes = comp_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid    = rsp_valid_ff;
   assign average_value = rsp_data_ff;
   assign frame_last    = rsp_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/box_average_downsampler.sv @@
// Top level of the box-average downsampler: joins controller and datapath.
// Depends on bad_pkg, bad_controller and bad_datapath.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  req      | in        | req_tvalid/req_tready  | tdata[7:0] pixel_value
//  rsp      | out       | rsp_tvalid/rsp_tready  | tdata[7:0] average_value,
//           |           |                        | tlast frame_last
//  csr      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// An item that completes no block is accepted, then its column sum gets a
// read-modify-write on the single-port sum memory. An item that completes a
// block goes through the same two steps, then the restoring divider, then the
// hand-off of the result to the output register, which a held result can stall.
// The output register lets the next item in while a result waits. Reset needs
// no clearing pass; sums are written before use.
`default_nettype none

module box_average_downsampler
   import bad_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel_value
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [PIX_W-1:0]           rsp_tdata,   // [7:0] average_value
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   bad_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bad_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pixel_value   (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .average_value (rsp_tdata),
      .frame_last    (rsp_tlast)
   );

   // A held result is never overwritten by the next one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register loaded while a result is still held");

   // One item at a time: after an accept the input side closes.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again while an item is in progress");

   // A result only appears after the divider hands one over.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result shown without a load from the divider");

endmodule

`default_nettype wire
